[sv/bounded_random_int_rejection_unit_assert.svh]
// assertion macros for the bounded random integer unit checker
// no dependencies; included by the checker file
`ifndef BOUNDED_RANDOM_INT_REJECTION_UNIT_ASSERT_SVH
`define BOUNDED_RANDOM_INT_REJECTION_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define BRIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brir assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define BRIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brir assertion failed");

`endif

[sv/brir_pkg.sv]
// shared types, constants and the xorshift32 step for the bounded random unit
// no dependencies
package brir_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W     = $clog2(WORD_W);

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  localparam logic [WORD_W-1:0]  RANGE_RST  = 32'd1000;
  localparam logic [WORD_W-1:0]  SEED_RST   = 32'd1;
  localparam logic [WORD_W-1:0]  THRESH_RST = 32'd296;  // (2^32 - 1000) mod 1000
  localparam logic [RETRY_W-1:0] RETRY_MAX  = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 1'b1;

  typedef struct packed {
    logic load;     // first draw of a request
    logic reseed;   // take seed instead of generator word for the first draw
    logic retry;    // draw again after a rejected product
    logic out_load; // capture result into the output register
  } brir_cmd_t;

  typedef struct packed {
    logic div_busy;  // threshold being recomputed
    logic draw_ok;   // current product is accepted
  } brir_status_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << SHIFT_A);
    y = y ^ (y >> SHIFT_B);
    y = y ^ (y << SHIFT_C);
    return y;
  endfunction

endpackage

[sv/brir_thr_div.sv]
// restoring divider, one quotient bit a cycle, giving (2^32 - r) mod r
// depends on brir_pkg
module brir_thr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [brir_pkg::WORD_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [brir_pkg::WORD_W-1:0]  result_o
);
  import brir_pkg::*;

  logic [WORD_W-1:0] dvd_q, rem_q, div_q;
  logic [WORD_W-1:0] rem_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   div_ext;

  assign div_ext = {1'b0, div_q};
  assign trial   = {rem_q, dvd_q[WORD_W-1]};

  always_comb begin
    if (trial >= div_ext) begin
      rem_d = WORD_W'(trial - div_ext);
    end else begin
      rem_d = trial[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= '0 - divisor_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = busy_q && (cnt_q == CNT_W'(WORD_W - 1));
  assign result_o = rem_d;

endmodule

[sv/brir_datapath.sv]
// generator, multiplier, reject compare, config registers and output register
// depends on brir_pkg and brir_thr_div
module brir_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  brir_pkg::brir_cmd_t            cmd_i,
  output brir_pkg::brir_status_t         status_o,
  input  logic                           cfg_we_i,
  input  logic [brir_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [brir_pkg::WORD_W-1:0]    cfg_data_i,
  output logic [brir_pkg::WORD_W-1:0]    value_o,
  output logic [brir_pkg::RETRY_W-1:0]   retries_o
);
  import brir_pkg::*;

  logic [WORD_W-1:0]  range_q, seed_q, gen_q, thr_q;
  logic [WORD_W-1:0]  raw_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RETRY_W-1:0] tries_q;
  logic [WORD_W-1:0]  value_q;
  logic [RETRY_W-1:0] retries_q;
  logic [WORD_W-1:0]  draw_src;
  logic [WORD_W-1:0]  draw_next;
  logic               range_wr, seed_wr;
  logic               div_busy, div_done;
  logic [WORD_W-1:0]  div_result;

  always_comb begin
    range_wr = 1'b0;
    seed_wr  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE: range_wr = 1'b1;
        REG_SEED:  seed_wr  = 1'b1;
        default: ;
      endcase
    end
  end

  brir_thr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (range_wr),
    .divisor_i(cfg_data_i),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .result_o (div_result)
  );

  // first draw may start from the seed, retries continue from the generator
  assign draw_src  = (cmd_i.load && cmd_i.reseed) ? seed_q : gen_q;
  assign draw_next = xorshift32(draw_src);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RST;
      seed_q  <= SEED_RST;
      gen_q   <= SEED_RST;
      thr_q   <= THRESH_RST;
    end else begin
      if (range_wr) begin
        range_q <= cfg_data_i;
      end
      if (div_done) begin
        thr_q <= div_result;
      end
      if (cmd_i.load || cmd_i.retry) begin
        gen_q <= draw_next;
      end else if (seed_wr) begin
        gen_q <= cfg_data_i;
      end
      if (seed_wr) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.retry) begin
      raw_q <= draw_next;
    end
    prod_q <= PROD_W'(raw_q) * PROD_W'(range_q);
    if (cmd_i.load) begin
      tries_q <= '0;
    end else if (cmd_i.retry && tries_q != RETRY_MAX) begin
      tries_q <= tries_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      value_q   <= prod_q[PROD_W-1:WORD_W];
      retries_q <= tries_q;
    end
  end

  // a zero raw word is always taken so a stuck generator cannot hang
  assign status_o.draw_ok  = (raw_q == '0) || (prod_q[WORD_W-1:0] >= thr_q);
  assign status_o.div_busy = div_busy;

  assign value_o   = value_q;
  assign retries_o = retries_q;

endmodule

[sv/brir_ctrl.sv]
// request sequencer: draw, multiply, check, retry and output handshake
// depends on brir_pkg
module brir_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_reseed_i,
  input  logic                   cfg_we_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output brir_pkg::brir_cmd_t    cmd_o,
  input  brir_pkg::brir_status_t status_i
);
  import brir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE) && !status_i.div_busy && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.load   = in_fire;
    cmd_o.reseed = in_reseed_i;
    if (state_q == ST_CHECK) begin
      cmd_o.retry    = !status_i.draw_ok;
      cmd_o.out_load = status_i.draw_ok && out_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (!status_i.draw_ok) begin
            state_q <= ST_MUL;
          end else if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/bounded_random_int_rejection_unit.sv]
// a request beat loads the raw word, MUL registers the product, and CHECK loads the result
// once the output is free, or draws again after a rejected raw draw; one request is taken at
//   a time; the single 32x32 multiplier and the draw/multiply/check sequence set that limit
// a range write recomputes the threshold in a bit-serial divider that holds off intake
// reset (async, active low): range 1000, seed and generator 1, threshold 296, no result held
module bounded_random_int_rejection_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [brir_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [0] reseed
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [brir_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] value, [35:32] retries
  input  logic                             cfg_we_i,
  input  logic [brir_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brir_pkg::WORD_W-1:0]      cfg_data_i
);
  import brir_pkg::*;

  brir_cmd_t          cmd;
  brir_status_t       status;
  logic [WORD_W-1:0]  value;
  logic [RETRY_W-1:0] retries;

  brir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_reseed_i(s_axis_tdata[0]),
    .cfg_we_i   (cfg_we_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  brir_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .value_o   (value),
    .retries_o (retries)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - WORD_W - RETRY_W)'(0), retries, value};

endmodule

[sv/brir_checker.sv]
// port-level checks for the bounded random integer unit, bound to the top level
// depends on brir_pkg and bounded_random_int_rejection_unit_assert.svh
`include "bounded_random_int_rejection_unit_assert.svh"

module brir_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [brir_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             cfg_we_i,
  input logic [brir_pkg::CFG_IDX_W-1:0]   cfg_idx_i
);
  import brir_pkg::*;

  // a request keeps intake closed through its multiply and check cycles
  `BRIR_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BRIR_ASSERT_NOW(a_busy_two_after, s_axis_tvalid && s_axis_tready, ##2 !s_axis_tready)
  // range write starts the threshold divider, intake waits for it
  `BRIR_ASSERT_NEXT(a_range_blocks, cfg_we_i && cfg_idx_i == REG_RANGE, !s_axis_tready)
  // a stalled result beat holds its data
  `BRIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bounded_random_int_rejection_unit brir_checker u_brir_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i)
);

[tb/bounded_random_int_rejection_unit_checker.sv]
// checker for the bounded random integer unit: tracks the register writes, predicts every
// drawn value and retry count, and compares each result beat with the oldest prediction
// depends on brir_pkg for widths, register indexes and reset values
module bounded_random_int_rejection_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic                             req_ready_i,
  input  logic [brir_pkg::IN_TDATA_W-1:0]  req_data_i,   // [0] reseed
  input  logic                             res_valid_i,
  input  logic                             res_ready_i,
  input  logic [brir_pkg::OUT_TDATA_W-1:0] res_data_i,   // [31:0] value, [35:32] retries
  input  logic                             cfg_we_i,
  input  logic [brir_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brir_pkg::WORD_W-1:0]      cfg_data_i,
  output int                               mismatch_cnt_o,
  output int                               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import brir_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [RETRY_W-1:0] retries;
  } draw_t;

  logic [WORD_W-1:0] range_q;
  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] gen_q;
  logic [WORD_W-1:0] thresh_q;
  logic [WORD_W-1:0] gen_after;
  draw_t             want;
  draw_t             got;
  draw_t             draws_q[$];

  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // (2^32 - r) mod r, done in 32 bits; zero range gives zero
  function automatic logic [WORD_W-1:0] thresh_for(input logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] neg;
    neg = '0 - r;
    return (r == '0) ? '0 : neg % r;
  endfunction

  function automatic draw_t draw_bounded(input  logic [WORD_W-1:0] rng,
                                         input  logic [WORD_W-1:0] thr,
                                         input  logic [WORD_W-1:0] gen_in,
                                         output logic [WORD_W-1:0] gen_out);
    logic [WORD_W-1:0] gen;
    logic [WORD_W-1:0] raw;
    logic [PROD_W-1:0] prod;
    draw_t             d;
    d.retries = '0;
    gen  = xs_advance(gen_in);
    raw  = gen;
    prod = PROD_W'(raw) * PROD_W'(rng);
    // a zero raw word is always taken, otherwise a stuck generator would spin forever
    while (raw != '0 && prod[WORD_W-1:0] < thr) begin
      if (d.retries != RETRY_MAX) d.retries = d.retries + 1'b1;
      gen  = xs_advance(gen);
      raw  = gen;
      prod = PROD_W'(raw) * PROD_W'(rng);
    end
    d.value = prod[PROD_W-1:WORD_W];
    gen_out = gen;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q        <= RANGE_RST;
      seed_q         <= SEED_RST;
      gen_q          <= SEED_RST;
      thresh_q       <= thresh_for(RANGE_RST);
      draws_q.delete();
      mismatch_cnt_o <= 0;
      outstanding_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE: begin
            range_q  <= cfg_data_i;
            thresh_q <= thresh_for(cfg_data_i);
          end
          REG_SEED: begin
            seed_q <= cfg_data_i;
            gen_q  <= cfg_data_i;
          end
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got.value   = res_data_i[WORD_W-1:0];
        got.retries = res_data_i[WORD_W+RETRY_W-1:WORD_W];
        if (draws_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual value %h retries %0d",
                   $time, got.value, got.retries);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = draws_q.pop_front();
          if (got.value !== want.value || got.retries !== want.retries) begin
            if (got.value !== want.value)
              $display("%0t: value mismatch, expected %h actual %h",
                       $time, want.value, got.value);
            if (got.retries !== want.retries)
              $display("%0t: retries mismatch, expected %0d actual %0d",
                       $time, want.retries, got.retries);
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = draw_bounded(range_q, thresh_q, req_data_i[0] ? seed_q : gen_q, gen_after);
        gen_q <= gen_after;
        draws_q.insert(draws_q.size(), want);
      end
      outstanding_o <= draws_q.size();
    end
  end

endmodule

[tb/bounded_random_int_rejection_unit_tb.sv]
// testbench top for the bounded random integer unit: clock, reset, register writes,
// request and result stream traffic with varying idle profiles, and the final verdict
// depends on brir_pkg, the unit itself and bounded_random_int_rejection_unit_checker
module bounded_random_int_rejection_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brir_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CFG_PAUSE   = 40;   // covers the threshold divider after a range write
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] reseed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] value, [35:32] retries
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [WORD_W-1:0]      cfg_data_i    = '0;

  int mismatch_cnt;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_cnt      = 0;
  int hold_left      = 0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  bounded_random_int_rejection_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bounded_random_int_rejection_unit_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .res_valid_i    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_data_i     (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_cnt, outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls, plus one long hold-off so the unit backs up
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(input logic reseed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(reseed);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    drain();
    repeat (CFG_PAUSE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_range();
    case ($urandom_range(4))
      0:       return WORD_W'($urandom_range(1, 1000));
      1:       return WORD_W'($urandom);
      // just above 2^31: about half of the raw words get rejected
      2:       return 32'h8000_0000 + WORD_W'($urandom_range(1, 4096));
      3:       return 32'hFFFF_FFFF - WORD_W'($urandom_range(0, 15));
      default: return WORD_W'(1) << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic random_phase(input int items, input bit hold);
    logic [WORD_W-1:0] seed;
    seed = WORD_W'($urandom);
    if (seed == '0) seed = WORD_W'(1);
    if ($urandom_range(1) == 0) begin
      write_reg(REG_RANGE, pick_range());
      write_reg(REG_SEED, seed);
    end else begin
      write_reg(REG_SEED, seed);
      write_reg(REG_RANGE, pick_range());
    end
    // receiver holds off while requests keep coming
    if (hold) long_hold_req = 1'b1;
    for (int i = 0; i < items; i++) send_request($urandom_range(9) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: range 1000, seed 1
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_RANGE, 32'hFFFF_FFFF);
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    write_reg(REG_RANGE, 32'd1);
    send_request(1'b0);
    send_request(1'b1);
    write_reg(REG_RANGE, 32'h8000_0001);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    // zero range: every product is zero
    write_reg(REG_RANGE, 32'd0);
    send_request(1'b0);
    send_request(1'b1);
    // zero seed: the generator sticks at zero and the zero word is taken
    write_reg(REG_RANGE, 32'h8000_0001);
    write_reg(REG_SEED, 32'd0);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_SEED, 32'd1);
    write_reg(REG_RANGE, 32'd2);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(REG_RANGE, 32'h8000_0000);
    send_request(1'b0);
    send_request(1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      random_phase(PHASE_ITEMS, p == 4);
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
